// ----- rtl/core/cpsm_pkg.sv -----
// Package for the capture period speed meter.
// Holds field widths, reset values, divider state and status types.
// No dependencies.
package cpsm_pkg;

  localparam int TIMER_WIDTH_DEFAULT = 16;
  localparam int TICK_RATE_W = 24;
  localparam int PERIOD_W = 16;
  localparam int SPEED_W = 8;
  localparam int LAST_W_MAX = 16;

  localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 24'd2000000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;

  localparam int DIV_STEPS = TICK_RATE_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);
  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- rtl/core/capture_period_speed_meter.sv -----
// Top level of the capture period speed meter.
// Forms the capture period, runs the serial divider, holds the result.
// Depends on cpsm_pkg and cpsm_serial_div.
//
// Each accepted capture timestamp yields one result: the wrapping period
// since the previous capture (the first one is measured against zero) and
// tick_rate / period, truncated and saturated at 255, or 0 for a zero period.
// Captures transfer only while the divider is idle, so a capture waits until
// the previous quotient has left the divider. The quotient comes out of a
// radix-2 divider one bit per cycle over the 24-bit tick rate. The acceptance
// edge loads the operands. The result becomes valid in the output register,
// and in_ready rises in the same cycle. The output register lets the next
// capture start while a result waits to be taken. A second finished quotient
// holds the divider, and with it the input, until that result transfers.
module capture_period_speed_meter #(
  parameter int TIMER_WIDTH = cpsm_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cpsm_pkg::TICK_RATE_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [TIMER_WIDTH-1:0]           capture_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cpsm_pkg::PERIOD_W-1:0]    period,
  output logic [cpsm_pkg::SPEED_W-1:0]     speed
);
  import cpsm_pkg::*;

  localparam int LastW = (TIMER_WIDTH < LAST_W_MAX) ? TIMER_WIDTH : LAST_W_MAX;

  logic [TICK_RATE_W-1:0] tick_rate;
  logic [LastW-1:0]       last_capture;
  logic [TIMER_WIDTH-1:0] cur_period;
  logic [PERIOD_W-1:0]    period_hold;
  logic                   in_xfer;
  logic                   load_out;

  div_status_t          div_status;
  logic [SPEED_W-1:0]   div_quotient;

  assign in_ready   = ~div_status.busy;
  assign in_xfer    = in_valid & in_ready;
  assign cur_period = capture_time - TIMER_WIDTH'(last_capture);
  assign load_out   = div_status.done & (~out_valid | out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= TICK_RATE_RESET;
    end else if (cfg_we) begin
      tick_rate <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_capture <= '0;
    end else if (in_xfer) begin
      last_capture <= capture_time[LastW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      period_hold <= PERIOD_W'(cur_period);
    end
  end

  cpsm_serial_div #(
    .DIVISOR_W(TIMER_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_xfer),
    .dividend (tick_rate),
    .divisor  (cur_period),
    .ack      (load_out),
    .status   (div_status),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      period <= period_hold;
      speed  <= div_quotient;
    end
  end

endmodule

// ----- rtl/core/cpsm_serial_div.sv -----
// Radix-2 serial divider: one quotient bit per cycle over the tick rate.
// Saturates the quotient to the speed field; zero divisor gives zero.
// Depends on cpsm_pkg.
module cpsm_serial_div #(
  parameter int DIVISOR_W = cpsm_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [cpsm_pkg::TICK_RATE_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]             divisor,
  input  logic                             ack,
  output cpsm_pkg::div_status_t            status,
  output logic [cpsm_pkg::SPEED_W-1:0]     quotient
);
  import cpsm_pkg::*;

  div_state_t state;
  div_state_t state_next;

  logic [STEP_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]   rem;
  logic [DIVISOR_W-1:0]   dvs;
  logic [TICK_RATE_W-1:0] num;
  logic [SPEED_W-1:0]     q;
  logic                   sat;
  logic                   zero;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               take;

  assign trial = {rem, num[TICK_RATE_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = ~diff[DIVISOR_W];

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (start) begin
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt == '0) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (ack) begin
          state_next = DIV_IDLE;
        end
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    status.busy = (state != DIV_IDLE);
    status.done = (state == DIV_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      cnt  <= STEP_LAST;
      rem  <= '0;
      dvs  <= divisor;
      num  <= dividend;
      q    <= '0;
      sat  <= 1'b0;
      zero <= (divisor == '0);
    end else if (state == DIV_RUN) begin
      cnt <= cnt - 1'b1;
      rem <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      num <= {num[TICK_RATE_W-2:0], 1'b0};
      q   <= {q[SPEED_W-2:0], take};
      sat <= sat | q[SPEED_W-1];
    end
  end

  assign quotient = zero ? '0 : (sat ? SPEED_MAX : q);

endmodule

// ----- tb/tb.sv -----
// Testbench for capture_period_speed_meter: streams capture timestamps under
// several tick rates and idling patterns and checks period and speed results
// against a cycle-free predictor. Depends on cpsm_pkg and the RTL top level.
module tb;
  import cpsm_pkg::*;

  localparam int TIMER_W = TIMER_WIDTH_DEFAULT;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [SPEED_W-1:0]  speed;
  } reading_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [TICK_RATE_W-1:0] cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [TIMER_W-1:0]     capture_time = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PERIOD_W-1:0]    period;
  logic [SPEED_W-1:0]     speed;

  logic [TIMER_W-1:0]     pending_captures[$];
  reading_t               expected_readings[$];

  logic [TIMER_W-1:0]     model_last_capture = '0;
  logic [TICK_RATE_W-1:0] model_tick_rate = TICK_RATE_RESET;
  logic [TIMER_W-1:0]     stim_time = '0;
  logic [TICK_RATE_W-1:0] stim_tick_rate = TICK_RATE_RESET;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int queued_count = 0;
  int checked_count = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  logic [PERIOD_W-1:0]    elapsed;
  logic [TICK_RATE_W-1:0] quotient;
  reading_t               predicted;
  reading_t               oldest;

  capture_period_speed_meter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .capture_time (capture_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .period       (period),
    .speed        (speed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  task queue_capture(input logic [TIMER_W-1:0] stamp);
    pending_captures.push_back(stamp);
    stim_time = stamp;
    queued_count++;
  endtask

  task queue_step(input int unsigned delta);
    queue_capture(stim_time + delta[TIMER_W-1:0]);
  endtask

  // bias the gap toward periods that land inside the unsaturated speed range
  task queue_random_capture();
    int unsigned pick;
    int unsigned delta;
    pick = $urandom_range(99);
    if (pick < 55) begin
      delta = stim_tick_rate / $urandom_range(300, 1);
      if (delta > 65535) begin
        delta = $urandom_range(65535);
      end else begin
        delta = delta + $urandom_range(2);
      end
    end else if (pick < 70) begin
      delta = $urandom_range(65535);
    end else if (pick < 80) begin
      delta = 0;
    end else if (pick < 90) begin
      delta = $urandom_range(16, 1);
    end else begin
      delta = 65535 - $urandom_range(16);
    end
    queue_step(delta);
  endtask

  task wait_drained();
    while (checked_count < queued_count) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_tick_rate(input logic [TICK_RATE_W-1:0] rate);
    cfg_we <= 1'b1;
    cfg_wdata <= rate;
    model_tick_rate <= rate;
    stim_tick_rate = rate;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct <= 0;
        receiver_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct <= 47;
        receiver_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct <= 0;
        receiver_stall_pct <= 47;
      end
      default: begin
        sender_idle_pct <= 30;
        receiver_stall_pct <= 30;
      end
    endcase
  endtask

  // predict on each input transfer, then advance or hold the payload
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        elapsed = capture_time - model_last_capture;
        quotient = (elapsed == '0) ? '0 : model_tick_rate / elapsed;
        predicted.period = elapsed;
        predicted.speed = (quotient > SPEED_MAX) ? SPEED_MAX : quotient[SPEED_W-1:0];
        expected_readings.push_back(predicted);
        model_last_capture = capture_time;
      end
      if (!in_valid || in_ready) begin
        if (pending_captures.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          capture_time <= pending_captures.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: period %0d speed %0d",
                                  period, speed));
      end else begin
        oldest = expected_readings.pop_front();
        if (period !== oldest.period)
          report_mismatch($sformatf("period got %0d expected %0d", period, oldest.period));
        if (speed !== oldest.speed)
          report_mismatch($sformatf("speed got %0d expected %0d (period %0d)",
                                    speed, oldest.speed, oldest.period));
      end
      checked_count++;
    end
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("capture_period_speed_meter test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TICK_RATE_W-1:0] rate;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // first capture runs against zero, then equal stamps, saturation, wraps
    queue_capture(16'd20000);
    queue_capture(16'd20000);
    queue_capture(16'd20001);
    queue_capture(16'hFFFF);
    queue_capture(16'h0000);
    queue_capture(16'h8000);
    queue_capture(16'h5555);
    queue_capture(16'hAAAA);
    queue_step(7843);
    queue_step(7844);
    queue_step(65535);

    wait_drained();
    write_tick_rate(24'hFFFFFF);
    queue_step(65535);
    queue_step(0);
    queue_step(1);

    wait_drained();
    write_tick_rate(24'd1);
    queue_step(1);
    queue_step(2);
    queue_step(0);

    // a zero rate must still be handled
    wait_drained();
    write_tick_rate('0);
    queue_step(1);
    queue_step(65535);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0: rate = TICK_RATE_RESET;
        3: rate = 24'hFFFFFF;
        2, 5: rate = TICK_RATE_W'($urandom_range(200000, 256));
        default: rate = TICK_RATE_W'($urandom_range(24'hFFFFFF, 1));
      endcase
      write_tick_rate(rate);
      set_idling(idle_mode_t'(p % 4));
      repeat (128) queue_random_capture();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_readings.size()));
    if (error_count == 0) begin
      $display("capture_period_speed_meter test passed");
    end else begin
      $display("capture_period_speed_meter test failed");
    end
    $finish;
  end

endmodule
